// ===== design/hsl_color_interpolator_macros.svh =====
// Assertion helpers for the HSL interpolator checker.
`ifndef HSL_COLOR_INTERPOLATOR_MACROS_SVH
`define HSL_COLOR_INTERPOLATOR_MACROS_SVH

// Clocked check, off while reset is asserted.
`define HCI_ASSERT_CLK(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Clocked check that also holds through reset.
`define HCI_ASSERT_RST(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

// ===== design/hci_pkg.sv =====
package hci_pkg;

  localparam int CB     = 12;          // component bits
  localparam int SLOTS  = 4;
  localparam int SLOT_W = 2;
  localparam int QDEPTH = 2;           // command queue depth
  localparam int PW     = 2 * CB + 1;  // product width
  localparam int QW     = CB + 2;      // quotient width of a divide by FULL
  localparam int DNW    = 2 * CB + 3;  // divider dividend width
  localparam int DDW    = CB + 3;      // divider divisor width

  localparam logic [CB-1:0] FULL = {CB{1'b1}};

  typedef enum logic {
    OP_LOAD = 1'b0,
    OP_EVAL = 1'b1
  } op_t;

  typedef struct packed {
    op_t             op;
    logic [SLOT_W-1:0] slot;
    logic [CB-1:0]   start_red;
    logic [CB-1:0]   start_green;
    logic [CB-1:0]   start_blue;
    logic [CB-1:0]   end_red;
    logic [CB-1:0]   end_green;
    logic [CB-1:0]   end_blue;
    logic [CB-1:0]   t_frac;
  } item_t;

  typedef struct packed {
    logic           start;
    logic [DNW-1:0] dividend;
    logic [DDW-1:0] divisor;
  } div_req_t;

  typedef struct packed {
    logic          done;
    logic [CB-1:0] quot;
  } div_rsp_t;

  typedef enum logic [3:0] {
    S_IDLE,
    S_LCLS,
    S_LSW,
    S_LHW,
    S_LNEXT,
    S_EH,
    S_EH2,
    S_ES,
    S_EL,
    S_EHI,
    S_EHI2,
    S_ECH,
    S_ECH2
  } state_t;

  // x / FULL, truncated: reciprocal estimate plus one correction step.
  function automatic logic [QW-1:0] div_full(input logic [PW-1:0] x);
    logic [PW+1:0] s;
    logic [QW-1:0] q;
    logic [PW:0]   qf;
    logic [PW-1:0] r;
    s  = (PW+2)'(x) + (PW+2)'(x >> CB);
    q  = QW'(s >> CB);
    qf = (PW+1)'({q, {CB{1'b0}}}) - (PW+1)'(q);
    r  = PW'((PW+1)'(x) - qf);
    if (r >= PW'(FULL)) q = q + 1'b1;
    return q;
  endfunction

  function automatic logic [CB-1:0] clamp_full(input logic signed [CB+1:0] v);
    logic [CB-1:0] res;
    if (v < 0) res = '0;
    else if (v > $signed((CB+2)'(FULL))) res = FULL;
    else res = v[CB-1:0];
    return res;
  endfunction

endpackage

// ===== design/hci_front.sv =====
module hci_front (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       start,
  input  logic                       in_op,
  input  logic [hci_pkg::SLOT_W-1:0] in_slot,
  input  logic [hci_pkg::CB-1:0]     in_start_red,
  input  logic [hci_pkg::CB-1:0]     in_start_green,
  input  logic [hci_pkg::CB-1:0]     in_start_blue,
  input  logic [hci_pkg::CB-1:0]     in_end_red,
  input  logic [hci_pkg::CB-1:0]     in_end_green,
  input  logic [hci_pkg::CB-1:0]     in_end_blue,
  input  logic [hci_pkg::CB-1:0]     in_t_frac,
  output logic                       busy,
  input  logic                       pop,
  output logic                       avail,
  output hci_pkg::item_t             item
);

  localparam int QAW = (hci_pkg::QDEPTH > 1) ? $clog2(hci_pkg::QDEPTH) : 1;
  localparam int QCW = $clog2(hci_pkg::QDEPTH + 1);

  hci_pkg::item_t   mem_r [hci_pkg::QDEPTH];
  logic [QAW-1:0]   wr_r, rd_r;
  logic [QCW-1:0]   cnt_r;
  hci_pkg::item_t   word;
  logic             keep, push, do_pop;

  // loads aimed past the table are dropped here
  always_comb begin
    word.op          = hci_pkg::op_t'(in_op);
    word.slot        = in_slot;
    word.start_red   = in_start_red;
    word.start_green = in_start_green;
    word.start_blue  = in_start_blue;
    word.end_red     = in_end_red;
    word.end_green   = in_end_green;
    word.end_blue    = in_end_blue;
    word.t_frac      = in_t_frac;
    keep = (word.op == hci_pkg::OP_EVAL) ||
           ({1'b0, in_slot} < (hci_pkg::SLOT_W+1)'(hci_pkg::SLOTS));
  end

  assign busy   = (cnt_r == QCW'(hci_pkg::QDEPTH));
  assign avail  = (cnt_r != '0);
  assign item   = mem_r[rd_r];
  assign push   = start && !busy && keep;
  assign do_pop = pop && avail;

  always_ff @(posedge clk) begin
    if (push) mem_r[wr_r] <= word;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_r  <= '0;
      rd_r  <= '0;
      cnt_r <= '0;
    end else begin
      if (push)
        wr_r <= (wr_r == QAW'(hci_pkg::QDEPTH - 1)) ? '0 : wr_r + 1'b1;
      if (do_pop)
        rd_r <= (rd_r == QAW'(hci_pkg::QDEPTH - 1)) ? '0 : rd_r + 1'b1;
      if (push && !do_pop)      cnt_r <= cnt_r + 1'b1;
      else if (!push && do_pop) cnt_r <= cnt_r - 1'b1;
    end
  end

endmodule

// ===== design/hci_div.sv =====
module hci_div (
  input  logic              clk,
  input  logic              rst_n,
  input  hci_pkg::div_req_t req,
  output hci_pkg::div_rsp_t rsp
);

  localparam int CB  = hci_pkg::CB;
  localparam int DNW = hci_pkg::DNW;
  localparam int CW  = $clog2(CB);

  logic [DNW-1:0] rem_r, dsh_r;
  logic [CB-1:0]  q_r;
  logic [CW-1:0]  cnt_r;
  logic           run_r, done_r;
  logic           hit;

  // restoring division, quotient known to fit CB bits, one bit per cycle
  assign hit = (rem_r >= dsh_r);
  assign rsp.done = done_r;
  assign rsp.quot = q_r;

  always_ff @(posedge clk) begin
    if (req.start) begin
      rem_r <= req.dividend;
      dsh_r <= DNW'(req.divisor) << (CB - 1);
      q_r   <= '0;
    end else if (run_r) begin
      if (hit) rem_r <= rem_r - dsh_r;
      dsh_r <= dsh_r >> 1;
      q_r   <= {q_r[CB-2:0], hit};
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      run_r  <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (req.start) begin
        run_r <= 1'b1;
        cnt_r <= CW'(CB - 1);
      end else if (run_r) begin
        if (cnt_r == '0) begin
          run_r  <= 1'b0;
          done_r <= 1'b1;
        end else begin
          cnt_r <= cnt_r - 1'b1;
        end
      end
    end
  end

endmodule

// ===== design/hci_back.sv =====
module hci_back (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       q_avail,
  input  hci_pkg::item_t             q_item,
  output logic                       q_pop,
  output hci_pkg::div_req_t          div_req,
  input  hci_pkg::div_rsp_t          div_rsp,
  output logic                       out_valid,
  output logic [hci_pkg::SLOT_W-1:0] out_slot,
  output logic [hci_pkg::CB-1:0]     out_red,
  output logic [hci_pkg::CB-1:0]     out_green,
  output logic [hci_pkg::CB-1:0]     out_blue,
  output logic                       out_last
);

  localparam int CB  = hci_pkg::CB;
  localparam int SW  = hci_pkg::SLOT_W;
  localparam int NS  = hci_pkg::SLOTS;
  localparam int PW  = hci_pkg::PW;
  localparam int QW  = hci_pkg::QW;
  localparam int DNW = hci_pkg::DNW;
  localparam int DDW = hci_pkg::DDW;
  localparam int NW  = CB + 3;
  localparam int XW  = CB + 4;
  localparam logic [CB-1:0] F = hci_pkg::FULL;
  localparam logic signed [XW-1:0] X1 = XW'(hci_pkg::FULL);
  localparam logic signed [XW-1:0] X2 = XW'(2 * hci_pkg::FULL);
  localparam logic signed [XW-1:0] X3 = XW'(3 * hci_pkg::FULL);
  localparam logic signed [XW-1:0] X4 = XW'(4 * hci_pkg::FULL);
  localparam logic signed [XW-1:0] X6 = XW'(6 * hci_pkg::FULL);

  typedef enum logic [1:0] {SEL_R, SEL_G, SEL_B} sel_t;
  typedef enum logic [1:0] {P_RISE, P_HI, P_FALL, P_LO} piece_t;

  hci_pkg::state_t state_r, state_nxt;

  // slot table
  logic [CB-1:0] sh_r [NS];
  logic [CB-1:0] ss_r [NS];
  logic [CB-1:0] sl_r [NS];
  logic [CB-1:0] eh_r [NS];
  logic [CB:0]   sd_r [NS];
  logic [CB:0]   ld_r [NS];

  hci_pkg::item_t item_r;
  logic [SW-1:0]  idx_r;
  logic           col_r;
  logic [1:0]     ch_r;
  logic [PW-1:0]  prod_r;
  logic           neg_r, wrap_r, case_r;
  piece_t         piece_r;
  logic [CB-1:0]  hb_r, hue_r, s_r, l_r, hi_r, lo_r, red_r, grn_r;
  logic [NW-1:0]  num_r;
  logic [CB-1:0]  dl_r, ht_r, st_r, lt_r, h0_r, s0_r, l0_r;
  logic           out_valid_r, out_last_r;
  logic [SW-1:0]  out_slot_r;
  logic [CB-1:0]  out_red_r, out_green_r, out_blue_r;

  // color classification
  logic [CB-1:0] cr, cg, cbl, mx, mn, dlt, lgt;
  sel_t          sel;
  logic [CB:0]   sum, den;
  logic [NW-1:0] num;

  always_comb begin
    cr  = col_r ? item_r.end_red   : item_r.start_red;
    cg  = col_r ? item_r.end_green : item_r.start_green;
    cbl = col_r ? item_r.end_blue  : item_r.start_blue;
    if (cr >= cg) begin
      if (cr >= cbl) begin
        sel = SEL_R; mx = cr; mn = (cbl < cg) ? cbl : cg;
      end else begin
        sel = SEL_B; mx = cbl; mn = cg;
      end
    end else begin
      if (cg < cbl) begin
        sel = SEL_B; mx = cbl; mn = cr;
      end else begin
        sel = SEL_G; mx = cg; mn = (cbl < cr) ? cbl : cr;
      end
    end
    sum = {1'b0, mx} + {1'b0, mn};
    dlt = mx - mn;
    lgt = sum[CB:1];
    den = (sum < {1'b0, F}) ? sum : (CB+1)'(2 * hci_pkg::FULL) - sum;
    // sector numerator, kept non-negative by the sector offsets
    unique case (sel)
      SEL_R: num = (cg >= cbl) ? NW'(cg) - NW'(cbl)
                               : NW'(cg) + (NW'(dlt) << 2) + (NW'(dlt) << 1) - NW'(cbl);
      SEL_G: num = NW'(cbl) + (NW'(dlt) << 1) - NW'(cr);
      default: num = NW'(cr) + (NW'(dlt) << 2) - NW'(cg);
    endcase
  end

  // evaluate datapath
  logic [CB-1:0]   ha, hz, hl, hh, tt, dd, m2;
  logic            swp, wrap;
  logic [CB:0]     sdv, ldv;
  logic [CB-1:0]   sd_abs, ld_abs;
  logic [QW-1:0]   divq;
  logic [CB:0]     hv;
  logic [CB-1:0]   hue_new, hi_new, lo_new, chv;
  logic [CB+1:0]   t_hi;
  logic signed [CB+1:0] sv;
  logic [CB+2:0]   h6;
  logic signed [XW-1:0] xs;
  piece_t          piece;
  logic [CB-1:0]   frac;
  logic [CB-1:0]   mul_a;
  logic [CB:0]     mul_b;
  logic [PW-1:0]   mul_p;
  logic            last;

  always_comb begin
    ha   = sh_r[idx_r];
    hz   = eh_r[idx_r];
    swp  = ha > hz;
    hl   = swp ? hz : ha;
    hh   = swp ? ha : hz;
    tt   = swp ? F - item_r.t_frac : item_r.t_frac;
    dd   = hh - hl;
    wrap = {dd, 1'b0} > {1'b0, F};
    m2   = wrap ? F - dd : dd;
    sdv  = sd_r[idx_r];
    ldv  = ld_r[idx_r];
    sd_abs = sdv[CB] ? CB'(~sdv + 1'b1) : sdv[CB-1:0];
    ld_abs = ldv[CB] ? CB'(~ldv + 1'b1) : ldv[CB-1:0];
    divq = hci_pkg::div_full(prod_r);
    last = (idx_r == SW'(NS - 1));

    // hue: backward path wraps once modulo one turn
    hv = (CB+1)'(hb_r) + (CB+1)'(F) - (CB+1)'(divq);
    if (wrap_r) hue_new = (hv >= (CB+1)'(F)) ? CB'(hv - (CB+1)'(F)) : hv[CB-1:0];
    else        hue_new = CB'((CB+1)'(hb_r) + (CB+1)'(divq));

    // saturation or lightness step, signed delta
    sv = neg_r ? $signed((CB+2)'({1'b0, (state_r == hci_pkg::S_ES) ? ss_r[idx_r] : sl_r[idx_r]}))
                 - $signed((CB+2)'(divq))
               : $signed((CB+2)'({1'b0, (state_r == hci_pkg::S_ES) ? ss_r[idx_r] : sl_r[idx_r]}))
                 + $signed((CB+2)'(divq));

    t_hi   = (CB+2)'(l_r) + (CB+2)'(s_r) - (CB+2)'(divq);
    hi_new = case_r ? t_hi[CB-1:0] : divq[CB-1:0];
    lo_new = CB'({l_r, 1'b0} - (CB+1)'(hi_new));

    // hue position times six, shifted per channel
    h6 = (NW'(hue_r) << 2) + (NW'(hue_r) << 1);
    xs = $signed(XW'(h6));
    if (ch_r == 2'd0)      xs = xs + X2;
    else if (ch_r == 2'd2) xs = xs - X2;
    if (xs < 0)  xs = xs + X6;
    if (xs > X6) xs = xs - X6;
    frac = '0;
    if (xs < X1) begin
      piece = P_RISE; frac = xs[CB-1:0];
    end else if (xs < X3) begin
      piece = P_HI;
    end else if (xs < X4) begin
      piece = P_FALL; frac = CB'(X4 - xs);
    end else begin
      piece = P_LO;
    end

    unique case (piece_r)
      P_HI:    chv = hi_r;
      P_LO:    chv = lo_r;
      default: chv = CB'((CB+1)'(lo_r) + (CB+1)'(divq));
    endcase

    // one shared multiplier, operands chosen by step
    mul_a = '0;
    mul_b = '0;
    unique case (state_r)
      hci_pkg::S_EH:  begin mul_a = tt;             mul_b = {1'b0, m2};     end
      hci_pkg::S_EH2: begin mul_a = item_r.t_frac;  mul_b = {1'b0, sd_abs}; end
      hci_pkg::S_ES:  begin mul_a = item_r.t_frac;  mul_b = {1'b0, ld_abs}; end
      hci_pkg::S_EHI: begin
        mul_a = l_r;
        mul_b = ({l_r, 1'b0} <= {1'b0, F}) ? {1'b0, F} + {1'b0, s_r} : {1'b0, s_r};
      end
      hci_pkg::S_ECH: begin mul_a = hi_r - lo_r;    mul_b = {1'b0, frac};   end
      default: ;
    endcase
    mul_p = PW'(mul_a) * PW'(mul_b);
  end

  // next state, queue pop, divider requests
  always_comb begin
    state_nxt        = state_r;
    q_pop            = 1'b0;
    div_req.start    = 1'b0;
    div_req.dividend = (DNW'(dlt) << CB) - DNW'(dlt);
    div_req.divisor  = DDW'(den);
    unique case (state_r)
      hci_pkg::S_IDLE: if (q_avail) begin
        q_pop     = 1'b1;
        state_nxt = (q_item.op == hci_pkg::OP_EVAL) ? hci_pkg::S_EH : hci_pkg::S_LCLS;
      end
      hci_pkg::S_LCLS: begin
        if (dlt == '0) state_nxt = hci_pkg::S_LNEXT;
        else begin
          div_req.start = 1'b1;
          state_nxt     = hci_pkg::S_LSW;
        end
      end
      hci_pkg::S_LSW: begin
        div_req.dividend = (DNW'(num_r) << CB) - DNW'(num_r);
        div_req.divisor  = (DDW'(dl_r) << 2) + (DDW'(dl_r) << 1);
        if (div_rsp.done) begin
          div_req.start = 1'b1;
          state_nxt     = hci_pkg::S_LHW;
        end
      end
      hci_pkg::S_LHW:   if (div_rsp.done) state_nxt = hci_pkg::S_LNEXT;
      hci_pkg::S_LNEXT: state_nxt = col_r ? hci_pkg::S_IDLE : hci_pkg::S_LCLS;
      hci_pkg::S_EH:    state_nxt = hci_pkg::S_EH2;
      hci_pkg::S_EH2:   state_nxt = hci_pkg::S_ES;
      hci_pkg::S_ES:    state_nxt = hci_pkg::S_EL;
      hci_pkg::S_EL:    state_nxt = hci_pkg::S_EHI;
      hci_pkg::S_EHI: begin
        if (s_r == '0) state_nxt = last ? hci_pkg::S_IDLE : hci_pkg::S_EH;
        else           state_nxt = hci_pkg::S_EHI2;
      end
      hci_pkg::S_EHI2:  state_nxt = hci_pkg::S_ECH;
      hci_pkg::S_ECH:   state_nxt = hci_pkg::S_ECH2;
      hci_pkg::S_ECH2: begin
        if (ch_r == 2'd2) state_nxt = last ? hci_pkg::S_IDLE : hci_pkg::S_EH;
        else              state_nxt = hci_pkg::S_ECH;
      end
      default: state_nxt = hci_pkg::S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) state_r <= hci_pkg::S_IDLE;
    else        state_r <= state_nxt;
  end

  // slot table, cleared at reset
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < NS; i++) begin
        sh_r[i] <= '0; ss_r[i] <= '0; sl_r[i] <= '0;
        eh_r[i] <= '0; sd_r[i] <= '0; ld_r[i] <= '0;
      end
    end else if (state_r == hci_pkg::S_LNEXT && col_r) begin
      sh_r[item_r.slot] <= h0_r;
      ss_r[item_r.slot] <= s0_r;
      sl_r[item_r.slot] <= l0_r;
      eh_r[item_r.slot] <= ht_r;
      sd_r[item_r.slot] <= {1'b0, st_r} - {1'b0, s0_r};
      ld_r[item_r.slot] <= {1'b0, lt_r} - {1'b0, l0_r};
    end
  end

  // working datapath
  always_ff @(posedge clk) begin
    unique case (state_r)
      hci_pkg::S_IDLE: begin
        item_r <= q_item;
        idx_r  <= '0;
        col_r  <= 1'b0;
      end
      hci_pkg::S_LCLS: begin
        lt_r  <= lgt;
        num_r <= num;
        dl_r  <= dlt;
        if (dlt == '0) begin
          ht_r <= '0;
          st_r <= '0;
        end
      end
      hci_pkg::S_LSW: if (div_rsp.done) st_r <= div_rsp.quot;
      hci_pkg::S_LHW: if (div_rsp.done) ht_r <= div_rsp.quot;
      hci_pkg::S_LNEXT: begin
        h0_r  <= ht_r;
        s0_r  <= st_r;
        l0_r  <= lt_r;
        col_r <= 1'b1;
      end
      hci_pkg::S_EH: begin
        prod_r <= mul_p;
        wrap_r <= wrap;
        hb_r   <= hl;
      end
      hci_pkg::S_EH2: begin
        hue_r  <= hue_new;
        prod_r <= mul_p;
        neg_r  <= sdv[CB];
      end
      hci_pkg::S_ES: begin
        s_r    <= hci_pkg::clamp_full(sv);
        prod_r <= mul_p;
        neg_r  <= ldv[CB];
      end
      hci_pkg::S_EL: l_r <= hci_pkg::clamp_full(sv);
      hci_pkg::S_EHI: begin
        prod_r <= mul_p;
        case_r <= !({l_r, 1'b0} <= {1'b0, F});
        ch_r   <= 2'd0;
        if (s_r == '0) idx_r <= idx_r + 1'b1;
      end
      hci_pkg::S_EHI2: begin
        hi_r <= hi_new;
        lo_r <= lo_new;
      end
      hci_pkg::S_ECH: begin
        prod_r  <= mul_p;
        piece_r <= piece;
      end
      hci_pkg::S_ECH2: begin
        if (ch_r == 2'd0) red_r <= chv;
        if (ch_r == 2'd1) grn_r <= chv;
        ch_r <= ch_r + 1'b1;
        if (ch_r == 2'd2) idx_r <= idx_r + 1'b1;
      end
      default: ;
    endcase
  end

  // result word, shown for one cycle
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= (state_r == hci_pkg::S_EHI && s_r == '0) ||
                     (state_r == hci_pkg::S_ECH2 && ch_r == 2'd2);
    end
  end

  always_ff @(posedge clk) begin
    if (state_r == hci_pkg::S_EHI && s_r == '0) begin
      out_slot_r  <= idx_r;
      out_last_r  <= last;
      out_red_r   <= l_r;
      out_green_r <= l_r;
      out_blue_r  <= l_r;
    end else if (state_r == hci_pkg::S_ECH2 && ch_r == 2'd2) begin
      out_slot_r  <= idx_r;
      out_last_r  <= last;
      out_red_r   <= red_r;
      out_green_r <= grn_r;
      out_blue_r  <= chv;
    end
  end

  assign out_valid = out_valid_r;
  assign out_slot  = out_slot_r;
  assign out_red   = out_red_r;
  assign out_green = out_green_r;
  assign out_blue  = out_blue_r;
  assign out_last  = out_last_r;

endmodule

// ===== design/hsl_color_interpolator.sv =====
// HSL color interpolator over a four-slot table. A load word (in_op = 0)
// converts its start and end RGB colors to HSL and stores them in slot
// in_slot; it returns nothing. An evaluate word (in_op = 1) walks all slots at
// fraction in_t_frac and emits one RGB word per slot, slot 0 first, with
// out_last on the final slot. Each result is on the out_ ports for exactly one
// cycle with out_valid high and is not held: capture it then. A two-entry
// command queue sits in front, so start is taken whenever busy is low, even
// while the engine works. Steps: the engine takes a word from the queue in
// its idle state. A load then runs, per non-grey color, a classify step, two
// 12-step divides on one shared serial divider and a store step, and only the
// classify and store steps for a grey one. An evaluate runs, per slot, the
// hue, saturation, lightness and high/low steps and then the channel steps,
// with its multiplies on a single shared multiplier; a grey slot leaves out
// the channel steps and returns its lightness.
module hsl_color_interpolator (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       start,
  output logic                       busy,
  input  logic                       in_op,
  input  logic [hci_pkg::SLOT_W-1:0] in_slot,
  input  logic [hci_pkg::CB-1:0]     in_start_red,
  input  logic [hci_pkg::CB-1:0]     in_start_green,
  input  logic [hci_pkg::CB-1:0]     in_start_blue,
  input  logic [hci_pkg::CB-1:0]     in_end_red,
  input  logic [hci_pkg::CB-1:0]     in_end_green,
  input  logic [hci_pkg::CB-1:0]     in_end_blue,
  input  logic [hci_pkg::CB-1:0]     in_t_frac,
  output logic                       out_valid,
  output logic [hci_pkg::SLOT_W-1:0] out_slot,
  output logic [hci_pkg::CB-1:0]     out_red,
  output logic [hci_pkg::CB-1:0]     out_green,
  output logic [hci_pkg::CB-1:0]     out_blue,
  output logic                       out_last
);

  logic              q_avail, q_pop;
  hci_pkg::item_t    q_item;
  hci_pkg::div_req_t div_req;
  hci_pkg::div_rsp_t div_rsp;

  // front: classify and queue incoming words
  hci_front u_front (
    .clk            (clk),
    .rst_n          (rst_n),
    .start          (start),
    .in_op          (in_op),
    .in_slot        (in_slot),
    .in_start_red   (in_start_red),
    .in_start_green (in_start_green),
    .in_start_blue  (in_start_blue),
    .in_end_red     (in_end_red),
    .in_end_green   (in_end_green),
    .in_end_blue    (in_end_blue),
    .in_t_frac      (in_t_frac),
    .busy           (busy),
    .pop            (q_pop),
    .avail          (q_avail),
    .item           (q_item)
  );

  // back: sequenced load and evaluate engine
  hci_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .q_avail   (q_avail),
    .q_item    (q_item),
    .q_pop     (q_pop),
    .div_req   (div_req),
    .div_rsp   (div_rsp),
    .out_valid (out_valid),
    .out_slot  (out_slot),
    .out_red   (out_red),
    .out_green (out_green),
    .out_blue  (out_blue),
    .out_last  (out_last)
  );

  // serial divider for saturation and hue on load
  hci_div u_div (
    .clk   (clk),
    .rst_n (rst_n),
    .req   (div_req),
    .rsp   (div_rsp)
  );

endmodule

// ===== design/hci_checker.sv =====
`include "hsl_color_interpolator_macros.svh"

module hci_checker (
  input logic                       clk,
  input logic                       rst_n,
  input logic                       busy,
  input logic                       out_valid,
  input logic [hci_pkg::SLOT_W-1:0] out_slot,
  input logic                       out_last
);

  `HCI_ASSERT_RST(a_reset_quiet, !rst_n |=> !out_valid && !busy, "not quiet after reset")
  `HCI_ASSERT_CLK(a_strobe_gap, out_valid |=> !out_valid, "result strobes back to back")
  `HCI_ASSERT_CLK(a_last_slot, out_valid |-> (out_last == (out_slot == hci_pkg::SLOT_W'(hci_pkg::SLOTS - 1))), "last flag off final slot")

endmodule

bind hsl_color_interpolator hci_checker u_chk (
  .clk       (clk),
  .rst_n     (rst_n),
  .busy      (busy),
  .out_valid (out_valid),
  .out_slot  (out_slot),
  .out_last  (out_last)
);

// ===== bench/testbench.sv =====
// Self-checking bench for hsl_color_interpolator.
// Load words store HSL endpoints per slot; evaluate words return one RGB word
// per slot. A behavioral predictor mirrors the slot table and the integer
// color math, and a monitor compares every out_valid word against the oldest
// expected word.
module testbench;
  timeunit 1ns;
  timeprecision 1ps;

  localparam longint FS = 4095;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic start = 1'b0;
  logic busy;
  logic in_op = 1'b0;
  logic [hci_pkg::SLOT_W-1:0] in_slot = '0;
  logic [hci_pkg::CB-1:0] in_start_red = '0, in_start_green = '0, in_start_blue = '0;
  logic [hci_pkg::CB-1:0] in_end_red = '0, in_end_green = '0, in_end_blue = '0;
  logic [hci_pkg::CB-1:0] in_t_frac = '0;
  logic out_valid;
  logic [hci_pkg::SLOT_W-1:0] out_slot;
  logic [hci_pkg::CB-1:0] out_red, out_green, out_blue;
  logic out_last;

  typedef struct packed {
    logic [hci_pkg::SLOT_W-1:0] slot;
    logic [hci_pkg::CB-1:0] red;
    logic [hci_pkg::CB-1:0] green;
    logic [hci_pkg::CB-1:0] blue;
    logic last;
  } color_word_t;

  color_word_t pending_colors[$];

  // predictor copy of the slot table
  longint tbl_h0[hci_pkg::SLOTS], tbl_s0[hci_pkg::SLOTS], tbl_l0[hci_pkg::SLOTS];
  longint tbl_h1[hci_pkg::SLOTS], tbl_ds[hci_pkg::SLOTS], tbl_dl[hci_pkg::SLOTS];

  int errors = 0;
  int n_loads = 0, n_evals = 0, n_words = 0;
  int send_gap_pct = 0;

  hsl_color_interpolator u_top (.*);

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  function automatic longint clip(longint v);
    if (v < 0) return 0;
    if (v > FS) return FS;
    return v;
  endfunction

  // t*v/FULL truncated toward zero
  function automatic longint mul_frac(longint t, longint v);
    longint p;
    p = t * v;
    if (p < 0) return -((-p) / FS);
    return p / FS;
  endfunction

  task automatic to_hsl(input longint r, input longint g, input longint b,
                        output longint h, output longint s, output longint l);
    longint mx, mn, num, sum, dl;
    int ch;
    if (r >= g) begin
      if (r >= b) begin ch = 0; mx = r; mn = (b < g) ? b : g; end
      else begin ch = 2; mx = b; mn = g; end
    end else begin
      if (g < b) begin ch = 2; mx = b; mn = r; end
      else begin ch = 1; mx = g; mn = (b < r) ? b : r; end
    end
    sum = mx + mn;
    dl = mx - mn;
    l = clip(sum / 2);
    if (dl == 0) begin
      h = 0;
      s = 0;
      return;
    end
    if (sum < FS) s = clip(dl * FS / sum);
    else s = clip(dl * FS / (2 * FS - sum));
    if (ch == 0) num = (g - b) + ((g < b) ? 6 * dl : 0);
    else if (ch == 1) num = (b - r) + 2 * dl;
    else num = (r - g) + 4 * dl;
    if (num < 0) num = 0;
    h = clip(num * FS / (6 * dl));
  endtask

  function automatic longint channel_level(longint lo, longint hi, longint x);
    if (x < 0) x += 6 * FS;
    if (x > 6 * FS) x -= 6 * FS;
    if (x < FS) return lo + (hi - lo) * x / FS;
    if (x < 3 * FS) return hi;
    if (x < 4 * FS) return lo + (hi - lo) * (4 * FS - x) / FS;
    return lo;
  endfunction

  // updates the table on a load, queues one word per slot on an evaluate
  task automatic predict_colors(input hci_pkg::item_t it);
    longint h0, s0, l0, h1, s1, l1, a, z, t, d, hue, s, l, hi, lo;
    color_word_t w;
    if (it.op == hci_pkg::OP_LOAD) begin
      to_hsl(it.start_red, it.start_green, it.start_blue, h0, s0, l0);
      to_hsl(it.end_red, it.end_green, it.end_blue, h1, s1, l1);
      tbl_h0[it.slot] = h0; tbl_s0[it.slot] = s0; tbl_l0[it.slot] = l0;
      tbl_h1[it.slot] = h1;
      tbl_ds[it.slot] = s1 - s0;
      tbl_dl[it.slot] = l1 - l0;
      return;
    end
    for (int i = 0; i < hci_pkg::SLOTS; i++) begin
      a = tbl_h0[i];
      z = tbl_h1[i];
      t = it.t_frac;
      if (a > z) begin
        d = a; a = z; z = d;
        t = FS - longint'(it.t_frac);
      end
      d = z - a;
      if (2 * d > FS) begin
        // shorter path wraps through zero
        a += FS;
        hue = a + mul_frac(t, z - a);
        if (hue < 0) hue = 0;
        hue = hue % FS;
      end else begin
        hue = a + t * d / FS;
      end
      s = clip(tbl_s0[i] + mul_frac(it.t_frac, tbl_ds[i]));
      l = clip(tbl_l0[i] + mul_frac(it.t_frac, tbl_dl[i]));
      hue = clip(hue);
      w.slot = i[hci_pkg::SLOT_W-1:0];
      w.last = (i == hci_pkg::SLOTS - 1);
      if (s == 0) begin
        w.red = l[hci_pkg::CB-1:0];
        w.green = l[hci_pkg::CB-1:0];
        w.blue = l[hci_pkg::CB-1:0];
      end else begin
        if (2 * l <= FS) hi = l * (FS + s) / FS;
        else hi = l + s - l * s / FS;
        lo = 2 * l - hi;
        w.red = hci_pkg::CB'(clip(channel_level(lo, hi, 6 * hue + 2 * FS)));
        w.green = hci_pkg::CB'(clip(channel_level(lo, hi, 6 * hue)));
        w.blue = hci_pkg::CB'(clip(channel_level(lo, hi, 6 * hue - 2 * FS)));
      end
      pending_colors.push_back(w);
    end
  endtask

  task automatic report_mismatch(input string what);
    errors++;
    $display("mismatch at %0t: %s", $realtime, what);
  endtask

  // monitor: the result word is valid for one cycle only
  always @(posedge clk) begin
    color_word_t exp_w;
    if (rst_n && out_valid) begin
      n_words++;
      if (pending_colors.size() == 0) begin
        report_mismatch($sformatf("unexpected word slot %0d", out_slot));
      end else begin
        exp_w = pending_colors.pop_front();
        if (out_slot !== exp_w.slot)
          report_mismatch($sformatf("slot %0d exp %0d", out_slot, exp_w.slot));
        if (out_red !== exp_w.red)
          report_mismatch($sformatf("slot %0d red %0d exp %0d",
                                    exp_w.slot, out_red, exp_w.red));
        if (out_green !== exp_w.green)
          report_mismatch($sformatf("slot %0d green %0d exp %0d",
                                    exp_w.slot, out_green, exp_w.green));
        if (out_blue !== exp_w.blue)
          report_mismatch($sformatf("slot %0d blue %0d exp %0d",
                                    exp_w.slot, out_blue, exp_w.blue));
        if (out_last !== exp_w.last)
          report_mismatch($sformatf("slot %0d last %0b exp %0b",
                                    exp_w.slot, out_last, exp_w.last));
      end
    end
  end

  // Drive one word, hold start until accepted (start && !busy at an edge).
  // Start stays high across back-to-back words; it is only lowered for a gap or by idle_input.
  task automatic send_word(input hci_pkg::item_t it);
    while (send_gap_pct != 0 && $urandom_range(99) < send_gap_pct) begin
      start <= 1'b0;
      @(posedge clk);
    end
    start <= 1'b1;
    in_op <= it.op;
    in_slot <= it.slot;
    in_start_red <= it.start_red;
    in_start_green <= it.start_green;
    in_start_blue <= it.start_blue;
    in_end_red <= it.end_red;
    in_end_green <= it.end_green;
    in_end_blue <= it.end_blue;
    in_t_frac <= it.t_frac;
    do @(posedge clk); while (busy);
    predict_colors(it);
    if (it.op == hci_pkg::OP_LOAD) n_loads++;
    else n_evals++;
  endtask

  task automatic idle_input();
    start <= 1'b0;
  endtask

  function automatic hci_pkg::item_t load_word(logic [1:0] k,
                                               logic [hci_pkg::CB-1:0] sr, sg, sb,
                                               logic [hci_pkg::CB-1:0] er, eg, eb);
    hci_pkg::item_t it;
    it = '0;
    it.op = hci_pkg::OP_LOAD;
    it.slot = k;
    it.start_red = sr; it.start_green = sg; it.start_blue = sb;
    it.end_red = er; it.end_green = eg; it.end_blue = eb;
    it.t_frac = hci_pkg::CB'($urandom);
    return it;
  endfunction

  function automatic hci_pkg::item_t eval_word(logic [hci_pkg::CB-1:0] t);
    hci_pkg::item_t it;
    it = hci_pkg::item_t'($bits(hci_pkg::item_t)'({$urandom, $urandom, $urandom}));
    it.op = hci_pkg::OP_EVAL;
    it.t_frac = t;
    return it;
  endfunction

  function automatic logic [hci_pkg::CB-1:0] rand_comp();
    case ($urandom_range(5))
      0: return '0;
      1: return hci_pkg::FULL;
      2: return hci_pkg::CB'($urandom_range(40));
      3: return hci_pkg::CB'(4095 - $urandom_range(40));
      default: return hci_pkg::CB'($urandom);
    endcase
  endfunction

  function automatic logic [hci_pkg::CB-1:0] rand_t();
    case ($urandom_range(4))
      0: return '0;
      1: return hci_pkg::FULL;
      2: return 12'd2048;
      default: return hci_pkg::CB'($urandom);
    endcase
  endfunction

  // evaluate on a reset table, grey and wrapped-hue cases, t extremes
  task automatic test_directed();
    send_word(eval_word(12'd0));
    send_word(eval_word(hci_pkg::FULL));
    send_word(load_word(2'd0, 12'd0, 12'd0, 12'd0,
                        hci_pkg::FULL, hci_pkg::FULL, hci_pkg::FULL));
    send_word(load_word(2'd1, hci_pkg::FULL, 12'd0, 12'd0,
                        12'd0, hci_pkg::FULL, 12'd0));
    send_word(load_word(2'd2, hci_pkg::FULL, 12'd0, 12'd200,
                        hci_pkg::FULL, 12'd200, 12'd0));
    send_word(load_word(2'd3, 12'd0, 12'd0, hci_pkg::FULL,
                        hci_pkg::FULL, 12'd0, hci_pkg::FULL));
    send_word(eval_word(12'd0));
    send_word(eval_word(hci_pkg::FULL));
    send_word(eval_word(12'd2048));
    // ties between channels, mid grey, sums around full scale
    send_word(load_word(2'd0, hci_pkg::FULL, hci_pkg::FULL, 12'd0,
                        12'd0, hci_pkg::FULL, hci_pkg::FULL));
    send_word(load_word(2'd1, 12'd2048, 12'd2048, 12'd2048, 12'd2047, 12'd2048,
                        12'd2048));
    send_word(load_word(2'd2, 12'd1, 12'd0, 12'd0,
                        hci_pkg::FULL, hci_pkg::FULL, 12'd4094));
    send_word(load_word(2'd3, 12'd0, hci_pkg::FULL, 12'd0,
                        12'd0, 12'd0, hci_pkg::FULL));
    send_word(eval_word(12'd1));
    send_word(eval_word(12'd4094));
    send_word(eval_word(12'd1365));
    // reversed hue order flips t
    send_word(load_word(2'd1, 12'd0, 12'd0, hci_pkg::FULL,
                        hci_pkg::FULL, 12'd0, 12'd0));
    send_word(eval_word(12'd3000));
  endtask

  task automatic test_random(input int n_items, input int gap_pct);
    hci_pkg::item_t it;
    send_gap_pct = gap_pct;
    for (int i = 0; i < n_items; i++) begin
      if ($urandom_range(2) == 0) begin
        it = eval_word(rand_t());
      end else begin
        it = load_word(hci_pkg::SLOT_W'($urandom), rand_comp(), rand_comp(),
                       rand_comp(), rand_comp(), rand_comp(), rand_comp());
        // grey start endpoint now and then
        if ($urandom_range(5) == 0) begin
          it.start_green = it.start_red; it.start_blue = it.start_red;
        end
      end
      send_word(it);
    end
    send_gap_pct = 0;
  endtask

  task automatic wait_drained();
    idle_input();
    while (pending_colors.size() != 0) @(posedge clk);
    repeat (80) @(posedge clk);
  endtask

  initial begin
    for (int i = 0; i < hci_pkg::SLOTS; i++) begin
      tbl_h0[i] = 0; tbl_s0[i] = 0; tbl_l0[i] = 0;
      tbl_h1[i] = 0; tbl_ds[i] = 0; tbl_dl[i] = 0;
    end
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_directed();
    test_random(100, 0);
    test_random(100, 47);
    test_random(50, 17);
    test_random(40, 0);
    wait_drained();
    $display("covered %0d loads and %0d evaluates, %0d color words checked",
             n_loads, n_evals, n_words);
    if (errors == 0) begin
      $display("testbench: PASS");
    end else begin
      $display("testbench: FAIL");
    end
    $finish;
  end

  // ~310 words plus sender gaps, far below this
  initial begin
    #5ms;
    $display("timeout with %0d words outstanding", pending_colors.size());
    $display("testbench: FAIL");
    $finish;
  end
endmodule

// ===== files.f =====
+incdir+design
design/hci_pkg.sv
design/hci_front.sv
design/hci_div.sv
design/hci_back.sv
design/hsl_color_interpolator.sv
design/hci_checker.sv
bench/testbench.sv
